/* hdl/mlq_pkg.sv */
// ============================================================================
// mlq_pkg: shared types and constants of the multilevel ready queue
// Field widths, level arithmetic constants, status and opcode codes,
// and the encoder functions that the queue core uses.
// ============================================================================
package mlq_pkg;

    // Field widths
    localparam int SLOT_W   = 6;
    localparam int LVL_W    = 6;
    localparam int PRIO_W   = 6;
    localparam int CPU_W    = 24;
    localparam int NICE_W   = 6;
    localparam int ST_W     = 2;

    localparam int LEVELS      = 1 << LVL_W;
    localparam int MAX_THREADS = 1 << SLOT_W;
    localparam int TOP_LVL     = LEVELS - 1;

    // cpu / 400 = (|cpu| >> 4) / 25, the /25 done as a multiply by
    // ceil(2^24 / 25) and a shift; exact for every 20-bit operand.
    localparam int CPU_SHIFT   = 4;
    localparam int MAG_W       = CPU_W - CPU_SHIFT;
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP = 20'd671089;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam int LV_W        = QUO_W + 1;
    localparam logic signed [LV_W-1:0] LV_TOP = LV_W'(TOP_LVL);

    // Stream packing
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // Opcodes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_IDLE = 2'd1;
    localparam logic [ST_W-1:0] ST_DUP  = 2'd2;

    // Configuration register index (word address bit)
    localparam logic CFG_FEEDBACK_MODE = 1'b0;

    typedef struct packed {
        logic                     opcode;
        logic [SLOT_W-1:0]        slot;
        logic [PRIO_W-1:0]        prio;
        logic signed [CPU_W-1:0]  cpu;
        logic signed [NICE_W-1:0] nice;
    } in_item_t;

    typedef struct packed {
        logic                     opcode;
        logic [SLOT_W-1:0]        slot;
        logic [PRIO_W-1:0]        prio;
        logic                     neg;
        logic [QUO_W-1:0]         quo;
        logic signed [NICE_W-1:0] nice;
    } mid_item_t;

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] slot;
        logic [LVL_W-1:0]  level;
    } op_t;

    typedef struct packed {
        logic [SLOT_W-1:0] out_slot;
        logic [LVL_W-1:0]  out_level;
        logic [ST_W-1:0]   status;
        logic [LVL_W-1:0]  top_level;
        logic              any_ready;
    } result_t;

    // Index of the highest set bit, zero when none is set
    function automatic logic [LVL_W-1:0] prio_hi(input logic [LEVELS-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (v[i])
            begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

    // Index of the single set bit of a one-hot vector
    function automatic logic [SLOT_W-1:0] onehot_enc(input logic [MAX_THREADS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            if (v[i])
            begin
                r = r | SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* hdl/mlq_level.sv */
// ============================================================================
// mlq_level: level pipeline
// Registers the incoming item, scales the cpu usage by a reciprocal multiply,
// then forms the clamped level or takes prio. Three stages with valid/ready.
// ============================================================================
module mlq_level
    import mlq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     feedback_mode,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output op_t      out_op
);

    in_item_t  s1_reg;
    mid_item_t s2_reg;
    op_t       s3_reg;
    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    logic      rdy1;
    logic      rdy2;
    logic      rdy3;

    logic [CPU_W-1:0]         cpu_mag;
    logic [PROD_W-1:0]        prod;
    mid_item_t                s2_next;
    logic signed [LV_W-1:0]   quo_s;
    logic signed [LV_W-1:0]   nice_ext;
    logic signed [LV_W-1:0]   lv_raw;
    logic [LVL_W-1:0]         fb_level;
    op_t                      s3_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage A: magnitude, drop the factor 16, multiply by the reciprocal of 25
    always_comb
    begin
        cpu_mag = s1_reg.cpu[CPU_W-1] ? CPU_W'(-s1_reg.cpu) : CPU_W'(s1_reg.cpu);
        prod    = PROD_W'(cpu_mag[CPU_W-1:CPU_SHIFT]) * PROD_W'(RECIP);
        s2_next.opcode = s1_reg.opcode;
        s2_next.slot   = s1_reg.slot;
        s2_next.prio   = s1_reg.prio;
        s2_next.neg    = s1_reg.cpu[CPU_W-1];
        s2_next.quo    = prod[RECIP_SHIFT +: QUO_W];
        s2_next.nice   = s1_reg.nice;
    end

    // Stage B: level = top - cpu/400 - 2*nice, clamped
    always_comb
    begin
        quo_s    = $signed({1'b0, s2_reg.quo});
        if (s2_reg.neg)
        begin
            quo_s = -quo_s;
        end
        nice_ext = $signed({{(LV_W-NICE_W){s2_reg.nice[NICE_W-1]}}, s2_reg.nice});
        lv_raw   = LV_TOP - quo_s - (nice_ext <<< 1);
        priority if (lv_raw[LV_W-1])
        begin
            fb_level = '0;
        end
        else if (lv_raw > LV_TOP)
        begin
            fb_level = LVL_W'(TOP_LVL);
        end
        else
        begin
            fb_level = lv_raw[LVL_W-1:0];
        end
        s3_next.opcode = s2_reg.opcode;
        s3_next.slot   = s2_reg.slot;
        s3_next.level  = feedback_mode ? fb_level : LVL_W'(s2_reg.prio);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_reg <= in_item;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_op    = s3_reg;

endmodule

/* hdl/mlq_core.sv */
// ============================================================================
// mlq_core: queue state and result register
// One cell per thread slot holds its level, its predecessor in the level
// and head/tail marks; one operation per cycle unless a held result stalls it.
// ============================================================================
module mlq_core
    import mlq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  op_t     in_op,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic [MAX_THREADS-1:0] queued_reg;
    logic [MAX_THREADS-1:0] queued_next;
    logic [MAX_THREADS-1:0] head_reg;
    logic [MAX_THREADS-1:0] head_next;
    logic [MAX_THREADS-1:0] tail_reg;
    logic [MAX_THREADS-1:0] tail_next;
    logic [LEVELS-1:0]      nonempty_reg;
    logic [LEVELS-1:0]      nonempty_next;
    logic [LVL_W-1:0]       lvl_reg  [MAX_THREADS];
    logic [SLOT_W-1:0]      prev_reg [MAX_THREADS];
    logic                   res_valid_reg;
    result_t                res_reg;
    result_t                res_next;

    logic                   fire;
    logic [LVL_W-1:0]       top_cur;
    logic                   any_cur;
    logic [MAX_THREADS-1:0] tail_hit;
    logic [MAX_THREADS-1:0] head_hit;
    logic [MAX_THREADS-1:0] succ_hit;
    logic [SLOT_W-1:0]      tail_idx;
    logic [SLOT_W-1:0]      head_idx;
    logic                   dup;
    logic                   lvl_busy;
    logic                   enq_wr;
    logic                   deq_wr;

    assign in_ready = !res_valid_reg || res_ready;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        top_cur = prio_hi(nonempty_reg);
        any_cur = |nonempty_reg;
        for (int j = 0; j < MAX_THREADS; j++)
        begin
            tail_hit[j] = queued_reg[j] && tail_reg[j] && (lvl_reg[j] == in_op.level);
            head_hit[j] = queued_reg[j] && head_reg[j] && (lvl_reg[j] == top_cur);
        end
        tail_idx = onehot_enc(tail_hit);
        head_idx = onehot_enc(head_hit);
        // Only the live successor of the head points at it and is not a head
        for (int j = 0; j < MAX_THREADS; j++)
        begin
            succ_hit[j] = queued_reg[j] && !head_reg[j] && (prev_reg[j] == head_idx);
        end
        dup      = queued_reg[in_op.slot];
        lvl_busy = nonempty_reg[in_op.level];
        enq_wr   = fire && (in_op.opcode == OP_ENQ) && !dup;
        deq_wr   = fire && (in_op.opcode == OP_DEQ) && any_cur;
    end

    always_comb
    begin
        queued_next   = queued_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        if (enq_wr)
        begin
            if (lvl_busy)
            begin
                tail_next[tail_idx] = 1'b0;
            end
            queued_next[in_op.slot]    = 1'b1;
            tail_next[in_op.slot]      = 1'b1;
            head_next[in_op.slot]      = !lvl_busy;
            nonempty_next[in_op.level] = 1'b1;
        end
        if (deq_wr)
        begin
            queued_next[head_idx] = 1'b0;
            head_next[head_idx]   = 1'b0;
            tail_next[head_idx]   = 1'b0;
            if (tail_reg[head_idx])
            begin
                nonempty_next[top_cur] = 1'b0;
            end
            else
            begin
                head_next = head_next | succ_hit;
            end
        end
    end

    always_comb
    begin
        res_next = '0;
        unique case (in_op.opcode)
            OP_ENQ:
            begin
                res_next.out_slot  = in_op.slot;
                res_next.out_level = in_op.level;
                res_next.status    = dup ? ST_DUP : ST_OK;
            end
            OP_DEQ:
            begin
                if (any_cur)
                begin
                    res_next.out_slot  = head_idx;
                    res_next.out_level = top_cur;
                    res_next.status    = ST_OK;
                end
                else
                begin
                    res_next.status = ST_IDLE;
                end
            end
            default:
            begin
                res_next.status = ST_OK;
            end
        endcase
        res_next.top_level = prio_hi(nonempty_next);
        res_next.any_ready = |nonempty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            nonempty_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            queued_reg   <= queued_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
        if (enq_wr)
        begin
            lvl_reg[in_op.slot]  <= in_op.level;
            prev_reg[in_op.slot] <= tail_idx;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_heads_match_levels: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(head_reg) == $countones(nonempty_reg))
        else $error("head count differs from non-empty level count");

    a_tails_match_levels: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tail_reg) == $countones(nonempty_reg))
        else $error("tail count differs from non-empty level count");

    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.any_ready == (|nonempty_reg)))
        else $error("held result disagrees with queue occupancy");

    a_dup_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_op.opcode == OP_ENQ) && queued_reg[in_op.slot])
        |=> ($stable(queued_reg) && $stable(nonempty_reg)))
        else $error("duplicate enqueue altered queue state");

endmodule

/* hdl/multilevel_priority_ready_queue.sv */
// ============================================================================
// multilevel_priority_ready_queue: 64-level ready queue, FIFO per level
// Top level: stream ports, configuration register, level pipeline and core.
// ============================================================================
// Usage
//   Slave stream: s_tuser is the opcode (0 enqueue, 1 dequeue); s_tdata
//   carries slot, given priority, recent cpu and nice. Master stream: one
//   result per item, m_tuser is the status (0 ok, 1 idle, 2 duplicate).
//   Register 0 (feedback_mode) at byte address 0 picks the level source:
//   given priority, or 63 - cpu/400 - 2*nice clamped to 0..63.
//   Write it only with no item in flight.
// Timing
//   An accepted item is loaded into the input register, then passes the
//   reciprocal multiply register and the level clamp register; the queue
//   update then loads the result register that drives m_tvalid. One item
//   per cycle sustained while m_tready stays high; the queue update path
//   (top-level encode, cell match, successor match) sets it.
// Reset and stalls
//   rst_n clears every level and slot mark and empties the pipeline.
//   While m_tready is low the held result stays put and the pipeline keeps
//   taking items until every stage is full, then s_tready drops.
// ============================================================================
module multilevel_priority_ready_queue
    import mlq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // slot[5:0] prio[11:6] cpu[35:12] nice[41:36]
    input  logic                  s_tuser,   // opcode
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // slot[5:0] level[11:6] top[17:12] any[18]
    output logic [ST_W-1:0]       m_tuser,   // status
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic     feedback_mode_reg;
    logic     cfg_wr;
    in_item_t in_item;
    logic     op_valid;
    logic     op_ready;
    op_t      op;
    result_t  res;

    // Configuration: single word, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_FEEDBACK_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedback_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            feedback_mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == CFG_FEEDBACK_MODE) ? {31'b0, feedback_mode_reg} : 32'b0;

    // Unpack the slave item
    assign in_item.opcode = s_tuser;
    assign in_item.slot   = s_tdata[5:0];
    assign in_item.prio   = s_tdata[11:6];
    assign in_item.cpu    = $signed(s_tdata[35:12]);
    assign in_item.nice   = $signed(s_tdata[41:36]);

    mlq_level u_level
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .feedback_mode (feedback_mode_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (in_item),
        .out_valid     (op_valid),
        .out_ready     (op_ready),
        .out_op        (op)
    );

    mlq_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (op_valid),
        .in_ready  (op_ready),
        .in_op     (op),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result; upper pad bits held at zero
    assign m_tdata = {5'b0, res.any_ready, res.top_level, res.out_level, res.out_slot};
    assign m_tuser = res.status;

endmodule
